// ----- design/shdu_pkg.sv -----
// Shared constants and types for the smoothed Heaviside / delta unit.
package shdu_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int HORNER_STEPS  = 6;

    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [30:0] Q30_HALF     = 31'h2000_0000;
    localparam logic [30:0] SAT31        = 31'h7FFF_FFFF;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [29:0] INV_PI_Q30   = 30'd341782638;
    localparam logic [25:0] INV_2PI2_Q30 = 26'd54396396;

    localparam logic [63:0] RCP_BASE = 64'h1_0000_0000;

    // Taylor divisors, innermost Horner term first
    localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

    // floor(2^32 / divisor)
    localparam logic [29:0] SIN_RCP [HORNER_STEPS] = '{
        30'(RCP_BASE / 64'd156), 30'(RCP_BASE / 64'd110), 30'(RCP_BASE / 64'd72),
        30'(RCP_BASE / 64'd42),  30'(RCP_BASE / 64'd20),  30'(RCP_BASE / 64'd6)};
    localparam logic [29:0] COS_RCP [HORNER_STEPS] = '{
        30'(RCP_BASE / 64'd182), 30'(RCP_BASE / 64'd132), 30'(RCP_BASE / 64'd90),
        30'(RCP_BASE / 64'd56),  30'(RCP_BASE / 64'd30),  30'(RCP_BASE / 64'd12)};

    typedef struct packed {
        logic        inband;
        logic        neg;
        logic        flip;
        logic [30:0] t;
        logic [31:0] x;
        logic [31:0] x2;
    } hside_t;

endpackage

// ----- design/smoothed_heaviside_delta_unit.sv -----
// Top level: smoothed Heaviside, scaled Heaviside and Dirac delta over a level-set band.
//
//  channel  dir  signals                     content
//  s_axis   in   s_tvalid s_tready s_tdata   [31:0] distance
//  m_axis   out  m_tvalid m_tready m_tdata   [30:0] delta_value, [55:31] heaviside_value,
//                                            [80:56] heaviside_scaled, [111:81] delta_scaled
//  cfg      in   cfg_wen cfg_wdata           [30:0] band_half_width
//
// One beat per cycle while the skid entry is empty; each beat passes through the two
// 31-stage dividers (r = psi/eps, delta = n/eps) and the 18-stage Horner pipeline.
// Reset clears all valid bits and loads band_half_width with 1.0.
// Stall: output register plus one skid entry; the whole pipeline freezes only when the
// skid entry is full, so no beat is lost or repeated.
module smoothed_heaviside_delta_unit #(
    parameter int FRAC_BITS = shdu_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,    // distance
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,    // delta_value, heaviside_value, heaviside_scaled, delta_scaled
    input  logic          cfg_wen,
    input  logic [30:0]   cfg_wdata   // band_half_width
);

    import shdu_pkg::*;

    localparam int HW  = FRAC_BITS + 1;
    localparam int NSH = (2 * FRAC_BITS >= 31) ? 2 * FRAC_BITS - 31 : 0;
    localparam int DSH = (2 * FRAC_BITS < 31) ? 31 - 2 * FRAC_BITS : 0;
    localparam int NW2 = 32 + NSH;
    localparam int DW2 = 31 + DSH;
    localparam int SW2 = 3 + 2 * HW;
    localparam int PW  = HW + 31;
    localparam logic [HW-1:0] H_ONE = HW'(1) << FRAC_BITS;

    function automatic logic [HW-1:0] hv_out(input logic signed [35:0] a);
        logic [31:0] cl;
        if (a[35])
        begin
            cl = '0;
        end
        else if (a[34:0] > 35'h0_8000_0000)
        begin
            cl = 32'h8000_0000;
        end
        else
        begin
            cl = a[31:0];
        end
        return HW'(cl >> (31 - FRAC_BITS));
    endfunction

    // configuration
    logic [30:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= 31'(1) << FRAC_BITS;
        end
        else if (cfg_wen)
        begin
            eps_reg <= (cfg_wdata == '0) ? 31'd1 : cfg_wdata;
        end
    end

    // pipeline enable and output skid
    logic          en;
    logic          out_v_reg;
    logic          skid_v_reg;
    logic [111:0]  out_reg;
    logic [111:0]  skid_reg;
    logic          e2_v_reg;
    logic [111:0]  e_data;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    // stage B: magnitude and band test
    logic          b_v_reg;
    logic          b_inband_reg;
    logic          b_neg_reg;
    logic [60:0]   b_num_reg;
    logic [31:0]   mag;
    logic          inband;

    assign mag    = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
    assign inband = mag <= {1'b0, eps_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_inband_reg <= inband;
            b_neg_reg    <= s_tdata[31];
            b_num_reg    <= inband ? {mag[30:0], 30'b0} : '0;
        end
    end

    // r = |psi| / eps in Q30
    logic          d1_v;
    logic [30:0]   d1_q;
    logic [1:0]    d1_side;

    shdu_div #(
        .NW (61),
        .DW (31),
        .QW (31),
        .SW (2)
    ) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_v_reg),
        .num       (b_num_reg),
        .den       (eps_reg),
        .side      ({b_inband_reg, b_neg_reg}),
        .out_valid (d1_v),
        .quo       (d1_q),
        .side_out  (d1_side)
    );

    // T0: fold, T1: x = u*pi, T2: x^2
    logic          t0_v_reg, t1_v_reg;
    logic          t0_inb_reg, t0_neg_reg, t0_flip_reg;
    logic          t1_inb_reg, t1_neg_reg, t1_flip_reg;
    logic [30:0]   t0_t_reg, t1_t_reg;
    logic [29:0]   t0_u_reg;
    logic [31:0]   t1_x_reg;
    logic          fold;
    logic [61:0]   x_prod;
    logic [63:0]   x2_prod;

    assign fold    = d1_q > 31'(Q30_HALF);
    assign x_prod  = 62'(t0_u_reg) * 62'(PI_Q30);
    assign x2_prod = 64'(t1_x_reg) * 64'(t1_x_reg);

    // Horner chain: index 0 is the T2 register, index j+1 the end of step j
    logic          hrn_v_reg    [HORNER_STEPS+1];
    hside_t        hrn_side_reg [HORNER_STEPS+1];
    logic [30:0]   hrn_val_reg  [HORNER_STEPS+1][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_v_reg     <= 1'b0;
            t1_v_reg     <= 1'b0;
            hrn_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            t0_v_reg     <= d1_v;
            t1_v_reg     <= t0_v_reg;
            hrn_v_reg[0] <= t1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_inb_reg  <= d1_side[1];
            t0_neg_reg  <= d1_side[0];
            t0_flip_reg <= fold;
            t0_t_reg    <= d1_q;
            t0_u_reg    <= fold ? 30'(Q30_ONE - d1_q) : d1_q[29:0];

            t1_inb_reg  <= t0_inb_reg;
            t1_neg_reg  <= t0_neg_reg;
            t1_flip_reg <= t0_flip_reg;
            t1_t_reg    <= t0_t_reg;
            t1_x_reg    <= x_prod[61:30];

            hrn_side_reg[0].inband <= t1_inb_reg;
            hrn_side_reg[0].neg    <= t1_neg_reg;
            hrn_side_reg[0].flip   <= t1_flip_reg;
            hrn_side_reg[0].t      <= t1_t_reg;
            hrn_side_reg[0].x      <= t1_x_reg;
            hrn_side_reg[0].x2     <= x2_prod[61:30];
            hrn_val_reg[0][0]      <= Q30_ONE;
            hrn_val_reg[0][1]      <= Q30_ONE;
        end
    end

    logic          ha_v_reg    [HORNER_STEPS];
    hside_t        ha_side_reg [HORNER_STEPS];
    logic [31:0]   ha_y_reg    [HORNER_STEPS][2];
    logic          hb_v_reg    [HORNER_STEPS];
    hside_t        hb_side_reg [HORNER_STEPS];
    logic [31:0]   hb_y_reg    [HORNER_STEPS][2];
    logic [29:0]   hb_q_reg    [HORNER_STEPS][2];

    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ha_v_reg[j]    <= 1'b0;
                hb_v_reg[j]    <= 1'b0;
                hrn_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                ha_v_reg[j]    <= hrn_v_reg[j];
                hb_v_reg[j]    <= ha_v_reg[j];
                hrn_v_reg[j+1] <= hb_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ha_side_reg[j]    <= hrn_side_reg[j];
                hb_side_reg[j]    <= ha_side_reg[j];
                hrn_side_reg[j+1] <= hb_side_reg[j];
            end
        end

        // lane 0: sine series, lane 1: cosine series
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            localparam logic [7:0]  K   = (l == 0) ? SIN_DIV[j] : COS_DIV[j];
            localparam logic [29:0] RCP = (l == 0) ? SIN_RCP[j] : COS_RCP[j];

            logic [62:0] y_prod;
            logic [61:0] q_prod;
            logic [37:0] kq;
            logic [32:0] rem;
            logic [29:0] q_fix;

            assign y_prod = 63'(hrn_side_reg[j].x2) * 63'(hrn_val_reg[j][l]);
            assign q_prod = 62'(ha_y_reg[j][l]) * 62'(RCP);
            assign kq     = 38'(hb_q_reg[j][l]) * 38'(K);
            assign rem    = 33'(hb_y_reg[j][l]) - 33'(kq);
            assign q_fix  = hb_q_reg[j][l] + 30'(rem >= 33'(K));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ha_y_reg[j][l]    <= y_prod[61:30];
                    hb_y_reg[j][l]    <= ha_y_reg[j][l];
                    hb_q_reg[j][l]    <= q_prod[61:32];
                    hrn_val_reg[j+1][l] <= Q30_ONE - 31'(q_fix);
                end
            end
        end
    end

    // F1: final products, F2: sin cap, cos floor and sign
    logic          f1_v_reg, f2_v_reg;
    hside_t        f1_side_reg;
    logic [31:0]   f1_s_reg;
    logic [30:0]   f1_p_reg;
    logic          f2_inb_reg, f2_neg_reg;
    logic [30:0]   f2_t_reg;
    logic [30:0]   f2_sa_reg;
    logic [31:0]   f2_n_reg;
    logic [62:0]   s_prod;
    logic [62:0]   c_prod;
    logic [30:0]   cmag;

    assign s_prod = 63'(hrn_side_reg[HORNER_STEPS].x) * 63'(hrn_val_reg[HORNER_STEPS][0]);
    assign c_prod = 63'(hrn_side_reg[HORNER_STEPS].x2) * 63'(hrn_val_reg[HORNER_STEPS][1]);
    assign cmag   = (f1_p_reg >= Q30_ONE) ? '0 : Q30_ONE - f1_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= hrn_v_reg[HORNER_STEPS];
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_side_reg <= hrn_side_reg[HORNER_STEPS];
            f1_s_reg    <= s_prod[61:30];
            f1_p_reg    <= c_prod[61:31];

            f2_inb_reg  <= f1_side_reg.inband;
            f2_neg_reg  <= f1_side_reg.neg;
            f2_t_reg    <= f1_side_reg.t;
            f2_sa_reg   <= (f1_s_reg > 32'(Q30_ONE)) ? Q30_ONE : f1_s_reg[30:0];
            f2_n_reg    <= f1_side_reg.flip ? 32'(Q30_ONE) - 32'(cmag)
                                            : 32'(Q30_ONE) + 32'(cmag);
        end
    end

    // P1..P4: Heaviside sums and delta numerator
    logic          p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic          p1_inb_reg, p2_inb_reg, p3_inb_reg, p4_inb_reg;
    logic          p1_neg_reg, p2_neg_reg, p3_neg_reg, p4_neg_reg;
    logic [30:0]   p1_t_reg;
    logic [31:0]   p1_n_reg, p2_n_reg, p3_n_reg;
    logic [30:0]   p1_sp_reg, p1_sa2_reg, p1_tt_reg;
    logic [31:0]   p1_opr_reg;
    logic [26:0]   p2_sq_reg;
    logic [32:0]   p2_term_reg;
    logic signed [35:0] p2_acc_h_reg, p2_part_reg;
    logic signed [35:0] p3_acc_hs_reg;
    logic [HW-1:0] p3_h_reg, p4_h_reg, p4_hs_reg;
    logic [NW2-1:0] p4_num_reg;
    logic          p4_ovf_reg;
    logic [60:0]   sp_prod;
    logic [61:0]   sa2_prod;
    logic [61:0]   tt_prod;
    logic [56:0]   sq_prod;
    logic [62:0]   term_prod;
    logic [NW2-1:0] num2;
    logic [DW2-1:0] den2;

    assign sp_prod   = 61'(f2_sa_reg) * 61'(INV_PI_Q30);
    assign sa2_prod  = 62'(f2_sa_reg) * 62'(f2_sa_reg);
    assign tt_prod   = 62'(f2_t_reg) * 62'(f2_t_reg);
    assign sq_prod   = 57'(p1_sa2_reg) * 57'(INV_2PI2_Q30);
    assign term_prod = 63'(p1_sp_reg) * 63'(p1_opr_reg);
    assign num2      = NW2'(p3_n_reg) << NSH;
    assign den2      = DW2'(eps_reg) << DSH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= f2_v_reg;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_inb_reg <= f2_inb_reg;
            p1_neg_reg <= f2_neg_reg;
            p1_t_reg   <= f2_t_reg;
            p1_n_reg   <= f2_n_reg;
            p1_sp_reg  <= sp_prod[60:30];
            p1_sa2_reg <= sa2_prod[60:30];
            p1_tt_reg  <= tt_prod[61:31];
            p1_opr_reg <= f2_neg_reg ? 32'(Q30_ONE) - 32'(f2_t_reg)
                                     : 32'(Q30_ONE) + 32'(f2_t_reg);

            p2_inb_reg  <= p1_inb_reg;
            p2_neg_reg  <= p1_neg_reg;
            p2_n_reg    <= p1_n_reg;
            p2_sq_reg   <= sq_prod[56:30];
            p2_term_reg <= term_prod[62:30];
            p2_acc_h_reg <= p1_neg_reg
                ? 36'(Q30_ONE) - 36'(p1_t_reg) - 36'(p1_sp_reg)
                : 36'(Q30_ONE) + 36'(p1_t_reg) + 36'(p1_sp_reg);
            p2_part_reg <= p1_neg_reg
                ? 36'(Q30_HALF) - 36'(p1_t_reg) + 36'(p1_tt_reg)
                : 36'(Q30_HALF) + 36'(p1_t_reg) + 36'(p1_tt_reg);

            p3_inb_reg    <= p2_inb_reg;
            p3_neg_reg    <= p2_neg_reg;
            p3_n_reg      <= p2_n_reg;
            p3_h_reg      <= hv_out(p2_acc_h_reg);
            p3_acc_hs_reg <= p2_neg_reg
                ? p2_part_reg + 36'(p2_sq_reg) - 36'(p2_term_reg)
                : p2_part_reg + 36'(p2_sq_reg) + 36'(p2_term_reg);

            p4_inb_reg <= p3_inb_reg;
            p4_neg_reg <= p3_neg_reg;
            p4_h_reg   <= p3_h_reg;
            p4_hs_reg  <= hv_out(p3_acc_hs_reg);
            p4_num_reg <= num2;
            p4_ovf_reg <= (num2 >> 31) >= NW2'(den2);
        end
    end

    // delta = n * 2^(2F-31) / eps
    logic           d2_v;
    logic [30:0]    d2_q;
    logic [SW2-1:0] d2_side;

    shdu_div #(
        .NW (NW2),
        .DW (DW2),
        .QW (31),
        .SW (SW2)
    ) u_div_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p4_v_reg),
        .num       (p4_ovf_reg ? '0 : p4_num_reg),
        .den       (den2),
        .side      ({p4_inb_reg, p4_neg_reg, p4_ovf_reg, p4_h_reg, p4_hs_reg}),
        .out_valid (d2_v),
        .quo       (d2_q),
        .side_out  (d2_side)
    );

    // E1: band select, E2: 2*H*delta product
    logic           e1_v_reg;
    logic [30:0]    e1_delta_reg, e2_delta_reg;
    logic [HW-1:0]  e1_h_reg, e1_hs_reg, e2_h_reg, e2_hs_reg;
    logic [PW-1:0]  e2_prod_reg;
    logic           d2_inb, d2_neg, d2_ovf;
    logic [HW-1:0]  d2_h, d2_hs, h_out;
    logic [PW-1:0]  ds_full;
    logic [30:0]    ds;

    assign d2_inb  = d2_side[SW2-1];
    assign d2_neg  = d2_side[SW2-2];
    assign d2_ovf  = d2_side[SW2-3];
    assign d2_h    = d2_side[2*HW-1:HW];
    assign d2_hs   = d2_side[HW-1:0];
    assign h_out   = d2_neg ? '0 : H_ONE;
    assign ds_full = e2_prod_reg >> (FRAC_BITS - 1);
    assign ds      = (ds_full > PW'(SAT31)) ? SAT31 : ds_full[30:0];
    assign e_data  = {ds, 25'(e2_hs_reg), 25'(e2_h_reg), e2_delta_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_v_reg <= d2_v;
            e2_v_reg <= e1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_delta_reg <= !d2_inb ? '0 : (d2_ovf ? SAT31 : d2_q);
            e1_h_reg     <= d2_inb ? d2_h : h_out;
            e1_hs_reg    <= d2_inb ? d2_hs : h_out;

            e2_delta_reg <= e1_delta_reg;
            e2_h_reg     <= e1_h_reg;
            e2_hs_reg    <= e1_hs_reg;
            e2_prod_reg  <= PW'(e1_h_reg) * PW'(e1_delta_reg);
        end
    end

    // output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (m_tready || !out_v_reg)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= e2_v_reg;
            end
        end
        else if (e2_v_reg && en)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_v_reg)
        begin
            out_reg <= skid_v_reg ? skid_reg : e_data;
        end
        else if (e2_v_reg && en)
        begin
            skid_reg <= e_data;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry full while output register empty");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !$past(m_tready)))
        else $error("input stalled without a waiting result");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && m_tready) |=> (!skid_v_reg && m_tvalid))
        else $error("skid entry not drained after output beat");

endmodule

// ----- design/shdu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module shdu_div #(
    parameter int NW = 61,
    parameter int DW = 31,
    parameter int QW = 31,
    parameter int SW = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    // num >> QW must be below den
    logic          v_reg    [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic          in_v;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign in_v   = in_valid;
            assign rem_in = DW'(num >> QW);
            assign low_in = num[QW-1:0];
            assign q_in   = '0;
            assign s_in   = side;
        end
        else
        begin : g_rest
            assign in_v   = v_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign s_in   = side_reg[i-1];
        end

        assign trial = {rem_in, low_in[QW-1-i]};
        assign ge    = trial >= {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= in_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
                low_reg[i]  <= low_in;
                q_reg[i]    <= q_in | (QW'(ge) << (QW - 1 - i));
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule
